### src/gpfa_pkg.sv
// gpfa_pkg: shared widths, item structs, register indexes and helpers
// for the gravity pair force accumulator. No dependencies.
package gpfa_pkg;

  localparam int unsigned GPFA_ID_BITS   = 16;
  localparam int unsigned GPFA_FRAC_BITS = 16;

  localparam int unsigned ID_W    = 16;
  localparam int unsigned POS_W   = 32;
  localparam int unsigned MASS_W  = 32;
  localparam int unsigned RATE_W  = 48;
  localparam int unsigned DIFF_W  = 33;
  localparam int unsigned MAG_W   = 49;
  localparam int unsigned PROD_W  = 128;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 8'd1;

  localparam logic [CFG_DATA_W-1:0] GRAVITY_RESET = 32'h0001_0000;

  // largest term magnitude, 2^48
  localparam logic [PROD_W-1:0] TERM_CAP = 128'h1_0000_0000_0000;

  typedef struct packed {
    logic [ID_W-1:0]          own_id;
    logic signed [POS_W-1:0]  own_x;
    logic signed [POS_W-1:0]  own_y;
    logic signed [POS_W-1:0]  own_z;
    logic [MASS_W-1:0]        own_mass;
    logic [ID_W-1:0]          other_id;
    logic signed [POS_W-1:0]  other_x;
    logic signed [POS_W-1:0]  other_y;
    logic signed [POS_W-1:0]  other_z;
    logic [MASS_W-1:0]        other_mass;
    logic                     last_body;
  } in_item_t;

  typedef struct packed {
    logic signed [RATE_W-1:0] rate_x;
    logic signed [RATE_W-1:0] rate_y;
    logic signed [RATE_W-1:0] rate_z;
    logic                     saturated;
    logic                     too_close;
  } out_item_t;

  function automatic logic [MAG_W-1:0] cap_mag(logic [PROD_W-1:0] x);
    return (x > TERM_CAP) ? TERM_CAP[MAG_W-1:0] : x[MAG_W-1:0];
  endfunction

endpackage

### src/gravity_pair_force_accumulator.sv
// Gravity pair force accumulator: one pair item at a time on a shared multiplier.
// A counted pair holds the input from accept to next accept while it passes through
// normalisation, the square root and divider units and the three per-axis multiply
// chains. A skipped pair (same id or zero distance) goes straight to the finish state.
// A finished item waits in the output register while the next item is taken.
// Reset clears the sums, flags and sequencer; G resets to 1.0, mode to acceleration.
module gravity_pair_force_accumulator import gpfa_pkg::*; #(
  parameter int unsigned ID_BITS   = GPFA_ID_BITS,
  parameter int unsigned FRAC_BITS = GPFA_FRAC_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam logic [ID_W-1:0] ID_MASK = (ID_BITS >= ID_W) ? {ID_W{1'b1}} :
                                        ID_W'((64'd1 << ID_BITS) - 64'd1);

  localparam logic signed [50:0] ACC_MAX = 51'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [50:0] ACC_MIN = -51'sh0_8000_0000_0000;

  localparam logic [3:0] SQ_X   = 4'd0;
  localparam logic [3:0] SQ_Y   = 4'd1;
  localparam logic [3:0] SQ_Z   = 4'd2;
  localparam logic [3:0] SQ_END = 4'd3;

  localparam logic [3:0] RC_VV  = 4'd0;
  localparam logic [3:0] RC_V3  = 4'd1;
  localparam logic [3:0] RC_GM  = 4'd2;
  localparam logic [3:0] RC_END = 4'd3;

  localparam logic [3:0] AX_TERM = 4'd0;
  localparam logic [3:0] AX_PP0  = 4'd1;
  localparam logic [3:0] AX_PP1  = 4'd2;
  localparam logic [3:0] AX_PP2  = 4'd3;
  localparam logic [3:0] AX_PP3  = 4'd4;
  localparam logic [3:0] AX_PP4  = 4'd5;
  localparam logic [3:0] AX_CAP  = 4'd6;
  localparam logic [3:0] AX_MM0  = 4'd7;
  localparam logic [3:0] AX_MM1  = 4'd8;
  localparam logic [3:0] AX_MM2  = 4'd9;
  localparam logic [3:0] AX_MCAP = 4'd10;
  localparam logic [3:0] AX_ADD  = 4'd11;

  localparam logic [1:0] AXIS_LAST = 2'd2;

  typedef enum logic [10:0] {
    S_IDLE      = 11'b000_0000_0001,
    S_ABS       = 11'b000_0000_0010,
    S_SQR       = 11'b000_0000_0100,
    S_NORM      = 11'b000_0000_1000,
    S_SQRT_GO   = 11'b000_0001_0000,
    S_SQRT_WAIT = 11'b000_0010_0000,
    S_DIV_GO    = 11'b000_0100_0000,
    S_DIV_WAIT  = 11'b000_1000_0000,
    S_RECIP     = 11'b001_0000_0000,
    S_AXIS      = 11'b010_0000_0000,
    S_FINISH    = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic [3:0] uop_q, uop_d;
  logic [1:0] axis_q;

  logic [CFG_DATA_W-1:0] g_q;
  logic                  mode_q;

  in_item_t               item_q;
  logic [2:0][DIFF_W-1:0] d_in;
  logic [2:0][DIFF_W-1:0] d_q;
  logic [2:0][DIFF_W-1:0] d_abs;
  logic [2:0][31:0]       a_q;
  logic [2:0]             neg_q;
  logic                   s_q;
  logic                   big;
  logic                   id_eq;
  logic                   d_zero;

  logic [63:0]  q_q;
  logic [5:0]   e_q;
  logic [7:0]   n_calc;
  logic [6:0]   n_q;
  logic [31:0]  v3_q;
  logic [63:0]  gm_q;
  logic [63:0]  t_q;
  logic [PROD_W-1:0] acc_q;
  logic [MAG_W-1:0]  mag_q;

  logic signed [RATE_W-1:0] sum_q [3];
  logic clip_q;
  logic zero_q;

  logic [31:0] mul_a, mul_b;
  logic [63:0] p;
  logic        sq_start, sq_busy, dv_start, dv_busy;
  logic [31:0] root, recip;

  logic        out_valid_q;
  out_item_t   out_q;
  logic        out_load;

  logic signed [50:0] sum_ext, term_ext, add_res;
  logic        add_clip;
  logic signed [RATE_W-1:0] add_val;

  gpfa_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (p)
  );

  gpfa_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .x_i     (q_q),
    .busy_o  (sq_busy),
    .root_o  (root)
  );

  gpfa_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dv_start),
    .den_i   (root),
    .busy_o  (dv_busy),
    .quo_o   (recip)
  );

  // input differences, exact at 33 bits
  always_comb begin
    d_in = '0;
    d_in[0] = {in_i.own_x[POS_W-1], in_i.own_x} - {in_i.other_x[POS_W-1], in_i.other_x};
    d_in[1] = {in_i.own_y[POS_W-1], in_i.own_y} - {in_i.other_y[POS_W-1], in_i.other_y};
    d_in[2] = {in_i.own_z[POS_W-1], in_i.own_z} - {in_i.other_z[POS_W-1], in_i.other_z};
  end

  assign id_eq  = ((in_i.own_id & ID_MASK) == (in_i.other_id & ID_MASK));
  assign d_zero = (d_in == '0);

  always_comb begin
    big = 1'b0;
    for (int k = 0; k < 3; k++) begin
      d_abs[k] = d_q[k][DIFF_W-1] ? (~d_q[k] + 1'b1) : d_q[k];
      big      = big | d_abs[k][32] | d_abs[k][31];
    end
  end

  assign n_calc = 8'd125 + 8'({s_q, 1'b0}) - 8'(FRAC_BITS) - 8'(3 * e_q[5:1]);

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == S_SQR) begin
      case (uop_q)
        SQ_X:    begin mul_a = a_q[0]; mul_b = a_q[0]; end
        SQ_Y:    begin mul_a = a_q[1]; mul_b = a_q[1]; end
        SQ_Z:    begin mul_a = a_q[2]; mul_b = a_q[2]; end
        default: ;
      endcase
    end else if (state_q == S_RECIP) begin
      case (uop_q)
        RC_VV:   begin mul_a = recip;     mul_b = recip; end
        RC_V3:   begin mul_a = p[63:32];  mul_b = recip; end
        RC_GM:   begin mul_a = g_q;       mul_b = item_q.other_mass; end
        default: ;
      endcase
    end else if (state_q == S_AXIS) begin
      case (uop_q)
        AX_TERM: begin mul_a = v3_q;          mul_b = a_q[axis_q]; end
        AX_PP0:  begin mul_a = gm_q[31:0];    mul_b = p[31:0]; end
        AX_PP1:  begin mul_a = gm_q[31:0];    mul_b = t_q[63:32]; end
        AX_PP2:  begin mul_a = gm_q[63:32];   mul_b = t_q[31:0]; end
        AX_PP3:  begin mul_a = gm_q[63:32];   mul_b = t_q[63:32]; end
        AX_MM0:  begin mul_a = mag_q[31:0];   mul_b = item_q.own_mass; end
        AX_MM1:  begin mul_a = {15'b0, mag_q[48:32]}; mul_b = item_q.own_mass; end
        default: ;
      endcase
    end
  end

  // saturating add of the signed term into the selected axis sum
  always_comb begin
    sum_ext  = 51'(sum_q[axis_q]);
    term_ext = neg_q[axis_q] ? $signed({2'b0, mag_q}) : -$signed({2'b0, mag_q});
    add_res  = sum_ext + term_ext;
    add_clip = 1'b0;
    add_val  = add_res[RATE_W-1:0];
    if (add_res > ACC_MAX) begin
      add_val  = ACC_MAX[RATE_W-1:0];
      add_clip = 1'b1;
    end else if (add_res < ACC_MIN) begin
      add_val  = ACC_MIN[RATE_W-1:0];
      add_clip = 1'b1;
    end
  end

  always_comb begin
    state_d  = state_q;
    uop_d    = uop_q;
    sq_start = 1'b0;
    dv_start = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = (id_eq || d_zero) ? S_FINISH : S_ABS;
        end
      end
      S_ABS: begin
        state_d = S_SQR;
        uop_d   = SQ_X;
      end
      S_SQR: begin
        if (uop_q == SQ_END) begin
          state_d = S_NORM;
        end else begin
          uop_d = uop_q + 4'd1;
        end
      end
      S_NORM: begin
        if (q_q[63:62] != 2'b00) begin
          state_d = S_SQRT_GO;
        end
      end
      S_SQRT_GO: begin
        sq_start = 1'b1;
        state_d  = S_SQRT_WAIT;
      end
      S_SQRT_WAIT: begin
        if (!sq_busy) begin
          state_d = S_DIV_GO;
        end
      end
      S_DIV_GO: begin
        dv_start = 1'b1;
        state_d  = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (!dv_busy) begin
          state_d = S_RECIP;
          uop_d   = RC_VV;
        end
      end
      S_RECIP: begin
        if (uop_q == RC_END) begin
          state_d = S_AXIS;
          uop_d   = AX_TERM;
        end else begin
          uop_d = uop_q + 4'd1;
        end
      end
      S_AXIS: begin
        case (uop_q)
          AX_CAP: uop_d = mode_q ? AX_MM0 : AX_ADD;
          AX_ADD: begin
            uop_d = AX_TERM;
            if (axis_q == AXIS_LAST) begin
              state_d = S_FINISH;
            end
          end
          default: uop_d = uop_q + 4'd1;
        endcase
      end
      S_FINISH: begin
        if (!item_q.last_body) begin
          state_d = S_IDLE;
        end else if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control state, configuration and the running sums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      uop_q       <= '0;
      axis_q      <= '0;
      g_q         <= GRAVITY_RESET;
      mode_q      <= 1'b0;
      sum_q[0]    <= '0;
      sum_q[1]    <= '0;
      sum_q[2]    <= '0;
      clip_q      <= 1'b0;
      zero_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      uop_q   <= uop_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_GRAVITY: g_q    <= cfg_data_i;
          CFG_MODE:    mode_q <= cfg_data_i[0];
          default:     ;
        endcase
      end
      if (state_q == S_IDLE && in_valid_i && !id_eq && d_zero) begin
        zero_q <= 1'b1;
      end
      if (state_q == S_RECIP) begin
        axis_q <= '0;
      end
      if (state_q == S_AXIS && uop_q == AX_ADD) begin
        sum_q[axis_q] <= add_val;
        clip_q        <= clip_q | add_clip;
        axis_q        <= axis_q + 2'd1;
      end
      if (out_load) begin
        sum_q[0] <= '0;
        sum_q[1] <= '0;
        sum_q[2] <= '0;
        clip_q   <= 1'b0;
        zero_q   <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      item_q <= in_i;
      d_q    <= d_in;
    end
    if (out_load) begin
      out_q.rate_x    <= sum_q[0];
      out_q.rate_y    <= sum_q[1];
      out_q.rate_z    <= sum_q[2];
      out_q.saturated <= clip_q;
      out_q.too_close <= zero_q;
    end
    unique case (state_q)
      S_ABS: begin
        s_q <= big;
        for (int k = 0; k < 3; k++) begin
          a_q[k]   <= big ? d_abs[k][32:1] : d_abs[k][31:0];
          neg_q[k] <= d_q[k][DIFF_W-1];
        end
      end
      S_SQR: begin
        case (uop_q)
          SQ_Y:    q_q <= p;
          SQ_Z:    q_q <= q_q + p;
          SQ_END: begin
            q_q <= q_q + p;
            e_q <= '0;
          end
          default: ;
        endcase
      end
      S_NORM: begin
        if (q_q[63:56] == 8'd0) begin
          q_q <= q_q << 8;
          e_q <= e_q + 6'd8;
        end else if (q_q[63:62] == 2'b00) begin
          q_q <= q_q << 2;
          e_q <= e_q + 6'd2;
        end else begin
          n_q <= n_calc[6:0];
        end
      end
      S_RECIP: begin
        case (uop_q)
          RC_GM:   v3_q <= p[63:32];
          RC_END:  gm_q <= p;
          default: ;
        endcase
      end
      S_AXIS: begin
        case (uop_q)
          AX_PP0:  t_q   <= p;
          AX_PP1:  acc_q <= PROD_W'(p);
          AX_PP2:  acc_q <= acc_q + (PROD_W'(p) << 32);
          AX_PP3:  acc_q <= acc_q + (PROD_W'(p) << 32);
          AX_PP4:  acc_q <= acc_q + (PROD_W'(p) << 64);
          AX_CAP:  mag_q <= cap_mag(acc_q >> n_q);
          AX_MM1:  acc_q <= PROD_W'(p);
          AX_MM2:  acc_q <= acc_q + (PROD_W'(p) << 32);
          AX_MCAP: mag_q <= cap_mag(acc_q >> FRAC_BITS);
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign cfg_ready_o = 1'b1;

endmodule

### src/gpfa_mul.sv
// gpfa_mul: shared 32x32 unsigned multiplier with registered product.
// Does not depend on gpfa_pkg.
module gpfa_mul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] p_o
);

  logic [63:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= 64'(a_i) * 64'(b_i);
  end

  assign p_o = p_q;

endmodule

### src/gpfa_isqrt.sv
// gpfa_isqrt: bit-serial integer square root of a normalised 64-bit value,
// one result bit per cycle. Uses gpfa_pkg.
module gpfa_isqrt import gpfa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] x_i,
  output logic        busy_o,
  output logic [31:0] root_o
);

  logic [63:0] bit_q;
  logic [63:0] x_q;
  logic [63:0] res_q;
  logic [63:0] trial;

  // res never has bits at or below the current bit, so the add is an or
  assign trial = res_q | bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= '0;
    end else if (start_i) begin
      bit_q <= 64'h4000_0000_0000_0000;
    end else if (bit_q != '0) begin
      bit_q <= bit_q >> 2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= x_i;
      res_q <= '0;
    end else if (bit_q != '0) begin
      if (x_q >= trial) begin
        x_q   <= x_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
    end
  end

  assign busy_o = (bit_q != '0);
  assign root_o = res_q[31:0];

endmodule

### src/gpfa_div.sv
// gpfa_div: restoring divider giving floor((2^63 - 1) / den), den in [2^31, 2^32),
// one quotient bit per cycle. Uses gpfa_pkg.
module gpfa_div import gpfa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] den_i,
  output logic        busy_o,
  output logic [31:0] quo_o
);

  localparam logic [5:0] DIV_STEPS = 6'd32;

  logic [5:0]  cnt_q;
  logic [31:0] rem_q;
  logic [31:0] quo_q;
  logic [31:0] den_q;
  logic [32:0] trial;
  logic        ge;

  // dividend is all ones: every step brings in a one
  assign trial = {rem_q, 1'b1};
  assign ge    = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= DIV_STEPS;
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= 32'h7FFF_FFFF;
      quo_q <= '0;
      den_q <= den_i;
    end else if (cnt_q != '0) begin
      rem_q <= ge ? 32'(trial - {1'b0, den_q}) : trial[31:0];
      quo_q <= {quo_q[30:0], ge};
    end
  end

  assign busy_o = (cnt_q != '0);
  assign quo_o  = quo_q;

endmodule

### src/gpfa_checker.sv
// gpfa_checker: port-level assertions for the gravity pair force accumulator,
// bound to the top level. Uses gpfa_pkg for the item types.
module gpfa_checker import gpfa_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input out_item_t             out_o
);

  // one item at a time: an accepted item blocks the input next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after an item was taken");

  // a result only appears while an item is in work
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared with no item in work");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_o))
    else $error("stalled result changed");

endmodule

bind gravity_pair_force_accumulator gpfa_checker u_gpfa_checker (.*);

### test/testbench.sv
// Self-checking testbench for the gravity pair force accumulator.
// Depends on gpfa_pkg and the block. Expected sums come from a predictor held here.
`timescale 1ns / 1ps

module testbench;
  import gpfa_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 8'd2;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  gravity_pair_force_accumulator DUT (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor state and configuration copy
  bit [31:0] grav_g;
  bit mom_mode;
  longint acc_x, acc_y, acc_z;
  bit acc_clip, acc_close;
  out_item_t force_sums_q[$];

  int unsigned cycles, errors, results_seen, bodies_sent;
  bit idling_on = 1'b1;
  bit hold_req;

  function automatic bit [63:0] int_sqrt(bit [63:0] x);
    bit [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic bit [48:0] clamp_shift(bit [127:0] p, int n);
    bit [127:0] sh;
    sh = (n >= 128) ? 128'd0 : p >> n;
    return (sh > 128'h1_0000_0000_0000) ? 49'h1_0000_0000_0000 : sh[48:0];
  endfunction

  function automatic longint axis_force(bit [32:0] d, bit [63:0] a, bit [63:0] v3,
                                       bit [63:0] gm, int n, bit [31:0] own_mass);
    bit [63:0] va;
    bit [48:0] mag;
    va = v3 * a;
    mag = clamp_shift(128'(gm) * 128'(va), n);
    if (mom_mode)
      mag = clamp_shift(128'(mag) * 128'(own_mass), GPFA_FRAC_BITS);
    return ($signed(d) > 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint clip_add(longint acc, longint t);
    longint r;
    r = acc + t;
    if (r > 64'sh7FFF_FFFF_FFFF) begin
      r = 64'sh7FFF_FFFF_FFFF;
      acc_clip = 1'b1;
    end
    if (r < -64'sh8000_0000_0000) begin
      r = -64'sh8000_0000_0000;
      acc_clip = 1'b1;
    end
    return r;
  endfunction

  function automatic void fold_pair(in_item_t it);
    bit signed [32:0] dx, dy, dz;
    bit [63:0] ax, ay, az, mx, q, r, v, v2, v3, gm;
    int s, e, n;
    out_item_t res;
    dx = {it.own_x[31], it.own_x} - {it.other_x[31], it.other_x};
    dy = {it.own_y[31], it.own_y} - {it.other_y[31], it.other_y};
    dz = {it.own_z[31], it.own_z} - {it.other_z[31], it.other_z};
    if (it.own_id[GPFA_ID_BITS-1:0] == it.other_id[GPFA_ID_BITS-1:0]) begin
      // same body adds nothing
    end else if (dx == 0 && dy == 0 && dz == 0) begin
      acc_close = 1'b1;
    end else begin
      ax = dx[32] ? 64'(-dx) & 64'h1_FFFF_FFFF : 64'(dx);
      ay = dy[32] ? 64'(-dy) & 64'h1_FFFF_FFFF : 64'(dy);
      az = dz[32] ? 64'(-dz) & 64'h1_FFFF_FFFF : 64'(dz);
      mx = (ax > ay) ? ax : ay;
      if (az > mx) mx = az;
      s = 0;
      e = 0;
      if (mx >> 31 != 0) begin
        s = 1;
        ax >>= 1;
        ay >>= 1;
        az >>= 1;
      end
      q = ax * ax + ay * ay + az * az;
      while (q < (64'd1 << 62)) begin
        q <<= 2;
        e += 2;
      end
      r = int_sqrt(q);
      v = 64'h7FFF_FFFF_FFFF_FFFF / r;
      v2 = (v * v) >> 32;
      v3 = (v2 * v) >> 32;
      gm = 64'(grav_g) * 64'(it.other_mass);
      n = 125 + 2 * s - GPFA_FRAC_BITS - (3 * e) / 2;
      if (n < 0) n = 0;
      acc_x = clip_add(acc_x, axis_force(dx, ax, v3, gm, n, it.own_mass));
      acc_y = clip_add(acc_y, axis_force(dy, ay, v3, gm, n, it.own_mass));
      acc_z = clip_add(acc_z, axis_force(dz, az, v3, gm, n, it.own_mass));
    end
    if (it.last_body) begin
      res.rate_x = acc_x[47:0];
      res.rate_y = acc_y[47:0];
      res.rate_z = acc_z[47:0];
      res.saturated = acc_clip;
      res.too_close = acc_close;
      force_sums_q.push_back(res);
      acc_x = 0;
      acc_y = 0;
      acc_z = 0;
      acc_clip = 1'b0;
      acc_close = 1'b0;
    end
  endfunction

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (force_sums_q.size() == 0) begin
        $error("result with nothing outstanding: %p", out_o);
        errors++;
      end else begin
        automatic out_item_t exp_sum = force_sums_q.pop_front();
        if (out_o.rate_x !== exp_sum.rate_x) begin
          $error("rate_x expected %h got %h", exp_sum.rate_x, out_o.rate_x);
          errors++;
        end
        if (out_o.rate_y !== exp_sum.rate_y) begin
          $error("rate_y expected %h got %h", exp_sum.rate_y, out_o.rate_y);
          errors++;
        end
        if (out_o.rate_z !== exp_sum.rate_z) begin
          $error("rate_z expected %h got %h", exp_sum.rate_z, out_o.rate_z);
          errors++;
        end
        if (out_o.saturated !== exp_sum.saturated) begin
          $error("saturated expected %b got %b", exp_sum.saturated, out_o.saturated);
          errors++;
        end
        if (out_o.too_close !== exp_sum.too_close) begin
          $error("too_close expected %b got %b", exp_sum.too_close, out_o.too_close);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("gravity_pair_force_accumulator regression: fail");
      $finish;
    end
  end

  // receiver: random stall bursts plus one long hold-off on request
  initial begin
    forever begin
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (1500) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_req = 1'b0;
        @(posedge clk_i);
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        @(posedge clk_i);
      end
    end
  end

  task automatic send_body(in_item_t it);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    fold_pair(it);
    bodies_sent++;
  endtask

  task automatic end_burst();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (force_sums_q.size() != 0) @(posedge clk_i);
    // an item with no result may still be in flight
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_GRAVITY) grav_g = data;
    else if (idx == CFG_MODE) mom_mode = data[0];
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_mass();
    return $urandom >> $urandom_range(0, 31);
  endfunction

  function automatic in_item_t rand_pair(in_item_t own);
    in_item_t it;
    int k;
    it = own;
    k = $urandom_range(0, 31);
    it.other_id = 16'($urandom);
    if (it.other_id == own.own_id && $urandom_range(0, 3) != 0) it.other_id ^= 16'h1;
    it.other_mass = rand_mass();
    if ($urandom_range(0, 9) == 0) begin
      it.other_x = $urandom;
      it.other_y = $urandom;
      it.other_z = $urandom;
    end else begin
      it.other_x = own.own_x + ($signed($urandom) >>> k);
      it.other_y = own.own_y + ($signed($urandom) >>> k);
      it.other_z = own.own_z + ($signed($urandom) >>> k);
    end
    if ($urandom_range(0, 40) == 0) begin
      it.other_x = own.own_x;
      it.other_y = own.own_y;
      it.other_z = own.own_z;
    end
    it.last_body = 1'b0;
    return it;
  endfunction

  // one sum: own body against 1 to 8 others, occasionally broken by a stray last
  task automatic send_sum();
    in_item_t own, it;
    int cnt;
    own = '0;
    own.own_id = 16'($urandom);
    own.own_x = $urandom;
    own.own_y = $urandom;
    own.own_z = $urandom;
    if ($urandom_range(0, 1)) begin
      own.own_x = $signed(own.own_x) >>> $urandom_range(0, 20);
      own.own_y = $signed(own.own_y) >>> $urandom_range(0, 20);
      own.own_z = $signed(own.own_z) >>> $urandom_range(0, 20);
    end
    own.own_mass = rand_mass();
    cnt = $urandom_range(1, 8);
    for (int i = 0; i < cnt; i++) begin
      it = rand_pair(own);
      it.last_body = (i == cnt - 1) || ($urandom_range(0, 30) == 0);
      send_body(it);
    end
  endtask

  task automatic test_directed();
    in_item_t b;
    b = '0;
    b.own_id = 16'd5;
    b.other_id = 16'd6;
    b.own_mass = 32'h0001_0000;
    b.other_mass = 32'h0001_0000;
    b.other_x = 32'h0001_0000;
    b.last_body = 1'b1;
    send_body(b);
    // same body skipped, then zero distance flagged
    b.other_id = 16'd5;
    b.last_body = 1'b0;
    send_body(b);
    b.other_id = 16'hFFFF;
    b.other_x = 32'd0;
    b.last_body = 1'b1;
    send_body(b);
    // opposite corners of the position range
    b.own_id = 16'hFFFF;
    b.other_id = 16'h0000;
    b.own_x = 32'h7FFF_FFFF;
    b.own_y = 32'h8000_0000;
    b.own_z = 32'h7FFF_FFFF;
    b.other_x = 32'h8000_0000;
    b.other_y = 32'h7FFF_FFFF;
    b.other_z = 32'h8000_0000;
    b.own_mass = 32'hFFFF_FFFF;
    b.other_mass = 32'hFFFF_FFFF;
    send_body(b);
    b.other_mass = 32'd0;
    send_body(b);
    // tiny distance, heavy body: accumulators clip
    b.own_x = 32'd0;
    b.own_y = 32'd0;
    b.own_z = 32'd0;
    b.other_x = 32'd1;
    b.other_y = 32'd0;
    b.other_z = 32'hFFFF_FFFF;
    b.other_mass = 32'hFFFF_FFFF;
    b.last_body = 1'b0;
    send_body(b);
    send_body(b);
    b.last_body = 1'b1;
    send_body(b);
    end_burst();
  endtask

  task automatic test_config_sweep();
    logic [31:0] g_vals[4] = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'h0001_0000};
    foreach (g_vals[i]) begin
      write_reg(CFG_GRAVITY, g_vals[i]);
      for (int m = 0; m < 2; m++) begin
        write_reg(CFG_MODE, m);
        repeat (8) send_sum();
        end_burst();
      end
    end
    // out-of-range index must leave registers untouched
    write_reg(CFG_UNUSED, 32'h1234_5678);
    write_reg(CFG_MODE, 32'hFFFF_FFFE);
    repeat (4) send_sum();
    end_burst();
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (6) send_sum();
    end_burst();
  endtask

  task automatic test_random_sums();
    while (bodies_sent < 1500) begin
      if ($urandom_range(0, 60) == 0) begin
        end_burst();
        write_reg(CFG_GRAVITY, $urandom >> $urandom_range(0, 24));
        write_reg(CFG_MODE, $urandom_range(0, 1));
      end
      send_sum();
    end
    end_burst();
  endtask

  task automatic test_no_idle();
    idling_on = 1'b0;
    while (bodies_sent < 1850) send_sum();
    end_burst();
  endtask

  initial begin
    grav_g = GRAVITY_RESET;
    mom_mode = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config_sweep();
    test_backpressure();
    test_random_sums();
    test_no_idle();
    $display("sent %0d bodies, checked %0d sums over gravity and mode settings",
             bodies_sent, results_seen);
    $display("skip, zero-distance, clipping and long receiver hold-off all exercised");
    if (errors == 0 && force_sums_q.size() == 0) begin
      $display("gravity_pair_force_accumulator regression: pass");
    end else begin
      $display("gravity_pair_force_accumulator regression: fail");
    end
    $finish;
  end

endmodule

### files.f
src/gpfa_pkg.sv
src/gpfa_mul.sv
src/gpfa_isqrt.sv
src/gpfa_div.sv
src/gravity_pair_force_accumulator.sv
src/gpfa_checker.sv
test/testbench.sv
